// File: rtl/ptgr_pkg.sv
package ptgr_pkg;

    localparam int GLYPH_SIZE   = 16;
    localparam int CHUNK_PIXELS = 8;
    localparam int BLANK_WIDTH  = 8;

    // one atlas word holds one glyph row: 16 bytes of one cell
    localparam int ATLAS_WORDS  = 4096;
    localparam int WORD_BITS    = GLYPH_SIZE * 8;
    localparam int GLYPHS       = 256;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_ORIGIN = 2'd1;
    localparam logic [1:0] FUNC_DRAW   = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    localparam int         CFG_IDX_W      = 2;
    localparam logic [1:0] CFG_WIDTH_IDX  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT_IDX = 2'd1;

    localparam logic [12:0] WIDTH_RESET  = 13'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic accept;       // input request taken this cycle
        logic scan_start;   // rebuild spacing tables
        logic draw_init;    // clear row/chunk counters, prefetch row 0
        logic newline;
        logic emit;         // load one chunk into the output register
        logic advance;      // move cursor past the glyph
    } ctl_cmd_t;

    typedef struct packed {
        logic req_draw;
        logic tables_ready;
        logic scan_done;
        logic is_newline;
        logic draw_stop;    // nothing (more) to emit for this glyph
        logic chunk_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/ptgr_ifs.sv
interface ptgr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [7:0]  char_code;
    logic [15:0] atlas_address;
    logic [7:0]  atlas_value;

    modport source (output valid, func, start_x, start_y, char_code, atlas_address,
                    atlas_value, input ready);
    modport sink   (input valid, func, start_x, start_y, char_code, atlas_address,
                    atlas_value, output ready);
endinterface

interface ptgr_chunk_if;
    logic        valid;
    logic        ready;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [63:0] pixels;
    logic [7:0]  write_mask;
    logic        last;

    modport source (output valid, dest_x, dest_y, pixels, write_mask, last, input ready);
    modport sink   (input valid, dest_x, dest_y, pixels, write_mask, last, output ready);
endinterface

interface ptgr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ptgr_pkg::CFG_IDX_W-1:0] index;
    logic [12:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/ptgr_ctrl.sv
module ptgr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ptgr_pkg::dp_status_t status,
    output ptgr_pkg::ctl_cmd_t   cmd
);

    typedef enum logic [3:0]
    {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_DRAW   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.req_draw)
                    begin
                        if (status.tables_ready)
                        begin
                            state_next = ST_LOOKUP;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.draw_init = 1'b1;
                if (status.is_newline)
                begin
                    cmd.newline = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (status.draw_stop)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.chunk_last)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ptgr_datapath.sv
module ptgr_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  ptgr_pkg::ctl_cmd_t               cmd,
    output ptgr_pkg::dp_status_t             status,
    // input request fields
    input  logic [1:0]                       func,
    input  logic [11:0]                      start_x,
    input  logic [11:0]                      start_y,
    input  logic [7:0]                       char_code,
    input  logic [15:0]                      atlas_address,
    input  logic [7:0]                       atlas_value,
    // configuration writes
    input  logic                             cfg_write,
    input  logic [ptgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [12:0]                      cfg_data,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [15:0]                      dest_x,
    output logic [15:0]                      dest_y,
    output logic [63:0]                      pixels,
    output logic [7:0]                       write_mask,
    output logic                             last
);

    // ---------------- storage ----------------
    logic [ptgr_pkg::WORD_BITS-1:0] atlas_mem [ptgr_pkg::ATLAS_WORDS];
    logic [9:0]                     glyph_mem [ptgr_pkg::GLYPHS];

    logic [ptgr_pkg::WORD_BITS-1:0] atlas_rd_reg;
    logic [9:0]                     glyph_rd_reg;
    logic [11:0]                    atlas_raddr;
    logic                           atlas_we;

    // ---------------- architectural state ----------------
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [15:0] cursor_x_reg;
    logic [15:0] cursor_x_next;
    logic [15:0] cursor_y_reg;
    logic [15:0] cursor_y_next;
    logic [11:0] margin_reg;
    logic        tables_ready_reg;
    logic [7:0]  code_reg;

    // ---------------- scan pipeline ----------------
    logic        scan_run_reg;
    logic [11:0] scan_cnt_reg;
    logic        scan_vld_reg;
    logic [11:0] scan_tag_reg;
    logic [15:0] scan_acc_reg;
    logic [15:0] col_mask;
    logic [3:0]  scan_first;
    logic [3:0]  scan_lastcol;
    logic [4:0]  tbl_first;
    logic [4:0]  tbl_end;
    logic        glyph_we;
    logic        scan_done;

    // ---------------- draw ----------------
    logic [3:0]  row_reg;
    logic [3:0]  row_next;
    logic        chunk_reg;
    logic [4:0]  g_first;
    logic [4:0]  g_end;
    logic [4:0]  g_width;
    logic [4:0]  off;
    logic [4:0]  remaining;
    logic [4:0]  shift_bytes;
    logic [ptgr_pkg::WORD_BITS-1:0] shifted;
    logic [16:0] y_cur;
    logic [16:0] y_nxt;
    logic        clip_cur;
    logic        row_end;
    logic        row_last;
    logic [16:0] x0;
    logic [63:0] chunk_pix;
    logic [7:0]  chunk_mask;
    logic [16:0] adv_sum;
    logic [16:0] nl_sum;

    logic        out_valid_reg;
    logic [15:0] dest_x_reg;
    logic [15:0] dest_y_reg;
    logic [63:0] pixels_reg;
    logic [7:0]  mask_reg;
    logic        last_reg;
    logic        out_free;

    // ---------------- memories ----------------
    assign atlas_we = cmd.accept && (func == ptgr_pkg::FUNC_WRITE);

    // scan walks {glyph, row}; drawing reads the row the counters move to
    assign atlas_raddr = scan_run_reg
        ? {scan_cnt_reg[11:8], scan_cnt_reg[3:0], scan_cnt_reg[7:4]}
        : {code_reg[7:4], row_next, code_reg[3:0]};

    always_ff @(posedge clk)
    begin
        if (atlas_we)
        begin
            atlas_mem[{atlas_address[15:8], atlas_address[7:4]}]
                [{atlas_address[3:0], 3'b000} +: 8] <= atlas_value;
        end
        atlas_rd_reg <= atlas_mem[atlas_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (glyph_we)
        begin
            glyph_mem[scan_tag_reg[11:4]] <= {tbl_first, tbl_end};
        end
        glyph_rd_reg <= glyph_mem[code_reg];
    end

    // ---------------- scan ----------------
    always_comb
    begin
        for (int k = 0; k < ptgr_pkg::GLYPH_SIZE; k++)
        begin
            col_mask[k] = scan_acc_reg[k] | (|atlas_rd_reg[8*k +: 8]);
        end
    end

    always_comb
    begin
        scan_first   = '0;
        scan_lastcol = '0;
        for (int k = ptgr_pkg::GLYPH_SIZE - 1; k >= 0; k--)
        begin
            if (col_mask[k])
            begin
                scan_first = 4'(k);
            end
        end
        for (int k = 0; k < ptgr_pkg::GLYPH_SIZE; k++)
        begin
            if (col_mask[k])
            begin
                scan_lastcol = 4'(k);
            end
        end
    end

    always_comb
    begin
        if (col_mask == '0)
        begin
            tbl_first = '0;
            tbl_end   = 5'(ptgr_pkg::BLANK_WIDTH);
        end
        else
        begin
            tbl_first = {1'b0, scan_first};
            tbl_end   = {1'b0, scan_lastcol} + 5'd1;
        end
    end

    assign glyph_we  = scan_vld_reg && (scan_tag_reg[3:0] == 4'hF);
    assign scan_done = scan_vld_reg && (scan_tag_reg == 12'hFFF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_run_reg <= 1'b0;
            scan_cnt_reg <= '0;
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                scan_run_reg <= 1'b1;
                scan_cnt_reg <= '0;
            end
            else if (scan_run_reg)
            begin
                scan_cnt_reg <= scan_cnt_reg + 12'd1;
                if (scan_cnt_reg == 12'hFFF)
                begin
                    scan_run_reg <= 1'b0;
                end
            end
            scan_vld_reg <= scan_run_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_tag_reg <= scan_cnt_reg;
        if (cmd.scan_start || glyph_we)
        begin
            scan_acc_reg <= '0;
        end
        else if (scan_vld_reg)
        begin
            scan_acc_reg <= col_mask;
        end
    end

    // ---------------- draw ----------------
    assign g_first = glyph_rd_reg[9:5];
    assign g_end   = glyph_rd_reg[4:0];
    assign g_width = (g_end > g_first) ? (g_end - g_first) : 5'd0;

    assign off         = {chunk_reg, 4'b0000} >> 1;
    assign remaining   = g_width - off;
    assign shift_bytes = g_first + off;
    assign shifted     = atlas_rd_reg >> {shift_bytes, 3'b000};

    assign y_cur    = {1'b0, cursor_y_reg} + 17'(row_reg);
    assign y_nxt    = y_cur + 17'd1;
    assign clip_cur = y_cur >= {4'b0000, height_reg};
    assign row_end  = chunk_reg || (g_width <= 5'(ptgr_pkg::CHUNK_PIXELS));
    assign row_last = (row_reg == 4'(ptgr_pkg::GLYPH_SIZE - 1))
                   || (y_nxt >= {4'b0000, height_reg});
    assign x0       = {1'b0, cursor_x_reg} + 17'(off);

    always_comb
    begin
        logic        pix_ok;
        logic [17:0] xk;
        chunk_pix  = '0;
        chunk_mask = '0;
        for (int k = 0; k < ptgr_pkg::CHUNK_PIXELS; k++)
        begin
            pix_ok = 5'(k) < remaining;
            xk     = {1'b0, x0} + 18'(k);
            if (pix_ok)
            begin
                chunk_pix[8*k +: 8] = shifted[8*k +: 8];
            end
            chunk_mask[k] = pix_ok && (xk < {5'b00000, width_reg});
        end
    end

    always_comb
    begin
        if (cmd.draw_init)
        begin
            row_next = '0;
        end
        else if (cmd.emit && row_end)
        begin
            row_next = row_reg + 4'd1;
        end
        else
        begin
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            chunk_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            if (cmd.draw_init || (cmd.emit && row_end))
            begin
                chunk_reg <= 1'b0;
            end
            else if (cmd.emit)
            begin
                chunk_reg <= 1'b1;
            end
        end
    end

    // ---------------- cursor and configuration ----------------
    assign adv_sum = {1'b0, cursor_x_reg} + 17'(g_width) + 17'd1;
    assign nl_sum  = {1'b0, cursor_y_reg} + 17'(ptgr_pkg::GLYPH_SIZE);

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (cmd.accept && (func == ptgr_pkg::FUNC_ORIGIN))
        begin
            cursor_x_next = {4'b0000, start_x};
            cursor_y_next = {4'b0000, start_y};
        end
        else if (cmd.newline)
        begin
            cursor_x_next = {4'b0000, margin_reg};
            cursor_y_next = nl_sum[16] ? 16'hFFFF : nl_sum[15:0];
        end
        else if (cmd.advance)
        begin
            cursor_x_next = adv_sum[16] ? 16'hFFFF : adv_sum[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            margin_reg       <= '0;
            tables_ready_reg <= 1'b0;
            width_reg        <= ptgr_pkg::WIDTH_RESET;
            height_reg       <= ptgr_pkg::HEIGHT_RESET;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            if (cmd.accept && (func == ptgr_pkg::FUNC_ORIGIN))
            begin
                margin_reg <= start_x;
            end
            if (atlas_we)
            begin
                tables_ready_reg <= 1'b0;
            end
            else if (scan_done)
            begin
                tables_ready_reg <= 1'b1;
            end
            if (cfg_write && (cfg_index == ptgr_pkg::CFG_WIDTH_IDX))
            begin
                width_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == ptgr_pkg::CFG_HEIGHT_IDX))
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            code_reg <= char_code;
        end
    end

    // ---------------- output register ----------------
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            dest_x_reg <= x0[15:0];
            dest_y_reg <= y_cur[15:0];
            pixels_reg <= chunk_pix;
            mask_reg   <= chunk_mask;
            last_reg   <= row_end && row_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dest_x     = dest_x_reg;
    assign dest_y     = dest_y_reg;
    assign pixels     = pixels_reg;
    assign write_mask = mask_reg;
    assign last       = last_reg;

    // ---------------- status ----------------
    always_comb
    begin
        status              = '0;
        status.req_draw     = (func == ptgr_pkg::FUNC_DRAW);
        status.tables_ready = tables_ready_reg;
        status.scan_done    = scan_done;
        status.is_newline   = (code_reg == ptgr_pkg::NEWLINE_CODE);
        status.draw_stop    = (g_width == 5'd0) || clip_cur;
        status.chunk_last   = row_end && row_last;
        status.out_free     = out_free;
    end

endmodule

// File: rtl/proportional_text_glyph_renderer_top.sv
// Channel   Dir   Payload
// req       in    func, start_x, start_y, char_code, atlas_address, atlas_value
// chunk     out   dest_x, dest_y, pixels, write_mask, last
// cfg       in    index (0 surface_width, 1 surface_height), data
//
// Atlas write, origin and unused codes complete when taken; a newline passes through lookup.
// A character passes through lookup, then emits one chunk per cycle while the output register is free
// (up to 32 chunks, none when every row is clipped). The first character after an atlas load first
// runs a spacing scan (one 16-byte atlas word per cycle over all 4096 glyph rows, then a registered read).
// Reset clears cursor, margin and table-ready flag; atlas contents are not cleared.
// A stalled chunk holds the draw loop; the final chunk can wait while the next request is taken.
module proportional_text_glyph_renderer_top
(
    input  logic         clk,
    input  logic         rst_n,
    ptgr_req_if.sink     req,
    ptgr_chunk_if.source chunk,
    ptgr_cfg_if.sink     cfg
);

    ptgr_pkg::ctl_cmd_t   ctl_cmd;
    ptgr_pkg::dp_status_t dp_status;

    assign cfg.ready = 1'b1;

    ptgr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (dp_status),
        .cmd       (ctl_cmd)
    );

    ptgr_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctl_cmd),
        .status        (dp_status),
        .func          (req.func),
        .start_x       (req.start_x),
        .start_y       (req.start_y),
        .char_code     (req.char_code),
        .atlas_address (req.atlas_address),
        .atlas_value   (req.atlas_value),
        .cfg_write     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .out_valid     (chunk.valid),
        .out_ready     (chunk.ready),
        .dest_x        (chunk.dest_x),
        .dest_y        (chunk.dest_y),
        .pixels        (chunk.pixels),
        .write_mask    (chunk.write_mask),
        .last          (chunk.last)
    );

endmodule
